FILE: rtl/pmteq_pkg.sv
`timescale 1ns / 1ps

package pmteq_pkg;

  // Default sizes of the event pool
  localparam int unsigned DEF_EVENT_SLOTS     = 16;
  localparam int unsigned DEF_PRIORITY_LEVELS = 8;

  // Microseconds in one second, wide enough for the unreduced sum
  localparam logic [20:0] USEC_PER_SEC = 21'd1000000;

  // Item function codes
  typedef enum logic {
    FUNC_REGISTER = 1'b0,
    FUNC_FIRE     = 1'b1
  } func_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_REGISTERED = 3'd0,
    STAT_FIRED      = 3'd1,
    STAT_FULL       = 3'd2,
    STAT_EMPTY      = 3'd3,
    STAT_BAD_PRI    = 3'd4
  } status_e;

  // Input item
  typedef struct packed {
    func_e       func;
    logic [3:0]  priority_req;
    logic [19:0] delay_us;
    logic [15:0] info;
    logic [7:0]  handler_id;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } in_t;

  // Result item
  typedef struct packed {
    status_e     status;
    logic [15:0] fired_info;
    logic [7:0]  fired_handler;
  } out_t;

  // Stored event, without its age rank
  typedef struct packed {
    logic [3:0]  prio;
    logic [31:0] due_sec;
    logic [19:0] due_usec;
    logic [15:0] info;
    logic [7:0]  handler;
  } slot_data_t;

  // Control of the earliest-event selector
  typedef struct packed {
    logic       clear;
    logic       eval;
    logic [3:0] level;
  } sel_ctrl_t;

endpackage

FILE: rtl/pmteq_ram.sv
`timescale 1ns / 1ps

module pmteq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pmteq_select.sv
`timescale 1ns / 1ps

module pmteq_select #(
  parameter int unsigned IdxW = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pmteq_pkg::sel_ctrl_t   ctrl_i,
  input  pmteq_pkg::slot_data_t  cand_i,
  input  logic [IdxW-1:0]        cand_rank_i,
  input  logic [IdxW-1:0]        cand_idx_i,
  output logic                   found_o,
  output logic [IdxW-1:0]        best_idx_o,
  output pmteq_pkg::slot_data_t  best_o,
  output logic [IdxW-1:0]        best_rank_o
);

  import pmteq_pkg::*;

  logic            found_q, found_d;
  logic [IdxW-1:0] idx_q, idx_d;
  slot_data_t      best_q, best_d;
  logic [IdxW-1:0] rank_q, rank_d;
  logic            eligible;
  logic            earlier;
  logic            take;

  // Order by due seconds, then microseconds, then age; only priorities above the level qualify
  always_comb begin
    eligible = cand_i.prio > ctrl_i.level;
    if (cand_i.due_sec != best_q.due_sec) begin
      earlier = cand_i.due_sec < best_q.due_sec;
    end else if (cand_i.due_usec != best_q.due_usec) begin
      earlier = cand_i.due_usec < best_q.due_usec;
    end else begin
      earlier = cand_rank_i < rank_q;
    end
    take = ctrl_i.eval && eligible && (!found_q || earlier);
  end

  // Keep the best candidate seen so far
  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    best_d  = best_q;
    rank_d  = rank_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
      idx_d   = cand_idx_i;
      best_d  = cand_i;
      rank_d  = cand_rank_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    best_q <= best_d;
    rank_q <= rank_d;
  end

  assign found_o     = found_q;
  assign best_idx_o  = idx_q;
  assign best_o      = best_q;
  assign best_rank_o = rank_q;

endmodule

FILE: rtl/priority_masked_timed_event_queue_top.sv
`timescale 1ns / 1ps

// Channel   Ports                      Handshake
// input     item_i (in_t)              taken when start is high and busy is low
// result    result_o (out_t)           shown for one cycle while done_o is high
//
// A register item reduces its due time, walks past the occupied slots to the first free one
// and writes there; a bad priority or a full pool answers on the cycle after the item.
// A fire item gives its result after one pass reads every slot through the
// single read port of the event memory; a second pass then renumbers the age
// ranks before busy falls.
// Reset empties the pool at once through the per-slot valid flags.
// The receiver cannot stall: done_o marks each result for exactly one cycle.

module priority_masked_timed_event_queue_top #(
  parameter int unsigned EVENT_SLOTS     = pmteq_pkg::DEF_EVENT_SLOTS,
  parameter int unsigned PRIORITY_LEVELS = pmteq_pkg::DEF_PRIORITY_LEVELS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  pmteq_pkg::in_t  item_i,
  output logic            done_o,
  output pmteq_pkg::out_t result_o
);

  import pmteq_pkg::*;

  localparam int unsigned IdxW  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(EVENT_SLOTS + 1);
  localparam int unsigned DataW = $bits(slot_data_t);
  localparam int unsigned EntW  = DataW + IdxW;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_NORM   = 7'b0000010,
    ST_FIND   = 7'b0000100,
    ST_WRITE  = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_DECIDE = 7'b0100000,
    ST_RANK   = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [EVENT_SLOTS-1:0] valid_q, valid_d;
  logic                   pend_q, pend_d;
  logic [IdxW-1:0]        pend_idx_q, pend_idx_d;
  logic                   step_q, step_d;
  logic                   done_q, done_d;
  out_t                   result_q, result_d;
  in_t                    item_q, item_d;
  logic [31:0]            sec_q, sec_d;
  logic [20:0]            usec_q, usec_d;

  logic                   accept;
  logic                   bad_pri;
  logic                   bad_level;
  logic                   pool_full;
  logic                   scan_read;

  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  logic [EntW-1:0]        ram_wdata;
  logic [EntW-1:0]        ram_rdata;
  slot_data_t             rd_data;
  logic [IdxW-1:0]        rd_rank;
  slot_data_t             new_data;

  sel_ctrl_t              sel_ctrl;
  logic                   sel_found;
  logic [IdxW-1:0]        sel_idx;
  slot_data_t             sel_best;
  logic [IdxW-1:0]        sel_rank;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Check priorities and pool space on the incoming item
  assign bad_pri   = (item_i.priority_req == 4'd0) ||
                     ({1'b0, item_i.priority_req} > 5'(PRIORITY_LEVELS));
  assign bad_level = ({1'b0, item_i.priority_req} >= 5'(PRIORITY_LEVELS));
  assign pool_full = (count_q == CntW'(EVENT_SLOTS));

  // Issue one slot read per cycle during the two passes
  assign scan_read = ((state_q == ST_SCAN) || (state_q == ST_RANK)) &&
                     (idx_q < CntW'(EVENT_SLOTS));

  assign rd_data = slot_data_t'(ram_rdata[EntW-1:IdxW]);
  assign rd_rank = ram_rdata[IdxW-1:0];

  always_comb begin
    new_data.prio     = item_q.priority_req;
    new_data.due_sec  = sec_q;
    new_data.due_usec = usec_q[19:0];
    new_data.info     = item_q.info;
    new_data.handler  = item_q.handler_id;
  end

  // Select the earliest eligible event during the first pass
  always_comb begin
    sel_ctrl.clear = accept && (item_i.func == FUNC_FIRE);
    sel_ctrl.eval  = (state_q == ST_SCAN) && pend_q && valid_q[pend_idx_q];
    sel_ctrl.level = item_q.priority_req;
  end

  // Write new events and rank updates back to the memory
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[IdxW-1:0];
    ram_wdata = {new_data, count_q[IdxW-1:0]};
    if (state_q == ST_WRITE) begin
      ram_we = 1'b1;
    end else if ((state_q == ST_RANK) && pend_q && valid_q[pend_idx_q] &&
                 (rd_rank > sel_rank)) begin
      ram_we    = 1'b1;
      ram_waddr = pend_idx_q;
      ram_wdata = {rd_data, rd_rank - IdxW'(1)};
    end
  end

  // Sequence the register and fire operations
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    count_d    = count_q;
    valid_d    = valid_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    step_d     = step_q;
    done_d     = 1'b0;
    result_d   = result_q;
    item_d     = item_q;
    sec_d      = sec_q;
    usec_d     = usec_q;

    if (scan_read) begin
      pend_d     = 1'b1;
      pend_idx_d = idx_q[IdxW-1:0];
      idx_d      = idx_q + CntW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d                 = item_i;
          result_d.fired_info    = '0;
          result_d.fired_handler = '0;
          idx_d                  = '0;
          if (item_i.func == FUNC_REGISTER) begin
            sec_d  = item_i.now_sec;
            usec_d = {1'b0, item_i.now_usec} + {1'b0, item_i.delay_us};
            step_d = 1'b0;
            if (bad_pri) begin
              done_d          = 1'b1;
              result_d.status = STAT_BAD_PRI;
            end else if (pool_full) begin
              done_d          = 1'b1;
              result_d.status = STAT_FULL;
            end else begin
              state_d = ST_NORM;
            end
          end else begin
            if (bad_level) begin
              done_d          = 1'b1;
              result_d.status = STAT_BAD_PRI;
            end else if (count_q == '0) begin
              done_d          = 1'b1;
              result_d.status = STAT_EMPTY;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_NORM: begin
        // Reduce the microsecond sum, at most twice
        if (usec_q >= USEC_PER_SEC) begin
          usec_d = usec_q - USEC_PER_SEC;
          sec_d  = sec_q + 32'd1;
        end
        step_d = 1'b1;
        if (step_q) begin
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        // Walk to the lowest free slot
        if (!valid_q[idx_q[IdxW-1:0]]) begin
          state_d = ST_WRITE;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      ST_WRITE: begin
        valid_d[idx_q[IdxW-1:0]] = 1'b1;
        count_d                  = count_q + CntW'(1);
        done_d                   = 1'b1;
        result_d.status          = STAT_REGISTERED;
        state_d                  = ST_IDLE;
      end
      ST_SCAN: begin
        if (pend_q && (idx_q == CntW'(EVENT_SLOTS))) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        done_d = 1'b1;
        if (!sel_found) begin
          result_d.status = STAT_EMPTY;
          state_d         = ST_IDLE;
        end else begin
          valid_d[sel_idx]       = 1'b0;
          count_d                = count_q - CntW'(1);
          result_d.status        = STAT_FIRED;
          result_d.fired_info    = sel_best.info;
          result_d.fired_handler = sel_best.handler;
          idx_d                  = '0;
          state_d                = ST_RANK;
        end
      end
      ST_RANK: begin
        if (pend_q && (idx_q == CntW'(EVENT_SLOTS))) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      count_q <= '0;
      valid_q <= '0;
      pend_q  <= 1'b0;
      step_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      valid_q <= valid_d;
      pend_q  <= pend_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    result_q   <= result_d;
    item_q     <= item_d;
    sec_q      <= sec_d;
    usec_q     <= usec_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  pmteq_ram #(
    .Width (EntW),
    .Depth (EVENT_SLOTS)
  ) u_event_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (scan_read),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  pmteq_select #(
    .IdxW (IdxW)
  ) u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sel_ctrl),
    .cand_i      (rd_data),
    .cand_rank_i (rd_rank),
    .cand_idx_i  (pend_idx_q),
    .found_o     (sel_found),
    .best_idx_o  (sel_idx),
    .best_o      (sel_best),
    .best_rank_o (sel_rank)
  );

endmodule
